FILE: sv/cif_pkg.sv
// Shared types, constants, microcode table and helpers for the tunable-white fader.
package cif_pkg;

  // Field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned CctW    = 7;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DivW    = TimeW + LevelW;
  localparam int unsigned DivSteps = DivW / 2;
  localparam int unsigned PcW     = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 1;
  localparam int unsigned ProdW   = 2 * LevelW;

  // Level constants
  localparam logic [CctW-1:0]   CctMax   = 7'd100;
  localparam logic [CctW-1:0]   CctMid   = 7'd50;
  localparam logic [LevelW-1:0] LevelMax = 8'd255;
  // 255/50 in 16-bit fixed point, rounded up
  localparam logic [18:0]       MapRecip = 19'd334234;

  typedef enum logic [OpW-1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_CCT = 2'd1,
    OP_FADE_INT = 2'd2,
    OP_SET_CCT  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LED_ON     = 1'b0,
    CFG_AUTO_WRITE = 1'b1
  } cfg_idx_e;

  // Datapath operation of one microcode step
  typedef enum logic [3:0] {
    UOP_DISPATCH  = 4'd0,
    UOP_TICK      = 4'd1,
    UOP_CHECK     = 4'd2,
    UOP_LOAD_I    = 4'd3,
    UOP_WAIT      = 4'd4,
    UOP_WRITE_I   = 4'd5,
    UOP_LOAD_C    = 4'd6,
    UOP_WRITE_C   = 4'd7,
    UOP_MAP       = 4'd8,
    UOP_MUL_W     = 4'd9,
    UOP_MUL_C     = 4'd10,
    UOP_SCALE_C   = 4'd11,
    UOP_OFF_CHECK = 4'd12,
    UOP_FINISH    = 4'd13
  } uop_e;

  // Jump condition; the step jumps to its target when it holds, else advances
  typedef enum logic [2:0] {
    COND_NEXT        = 3'd0,
    COND_NOT_TICK    = 3'd1,
    COND_NOT_ANIM    = 3'd2,
    COND_TIME_UP     = 3'd3,
    COND_I_SETTLED   = 3'd4,
    COND_C_SETTLED   = 3'd5,
    COND_DIV_BUSY    = 3'd6,
    COND_OUT_BLOCKED = 3'd7
  } cond_e;

  typedef struct packed {
    uop_e           uop;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  // Step addresses
  localparam logic [PcW-1:0] StepDispatch = 4'd0;
  localparam logic [PcW-1:0] StepTick     = 4'd1;
  localparam logic [PcW-1:0] StepCheck    = 4'd2;
  localparam logic [PcW-1:0] StepLoadI    = 4'd3;
  localparam logic [PcW-1:0] StepWaitI    = 4'd4;
  localparam logic [PcW-1:0] StepWriteI   = 4'd5;
  localparam logic [PcW-1:0] StepLoadC    = 4'd6;
  localparam logic [PcW-1:0] StepWaitC    = 4'd7;
  localparam logic [PcW-1:0] StepWriteC   = 4'd8;
  localparam logic [PcW-1:0] StepMap      = 4'd9;
  localparam logic [PcW-1:0] StepMulW     = 4'd10;
  localparam logic [PcW-1:0] StepMulC     = 4'd11;
  localparam logic [PcW-1:0] StepScaleC   = 4'd12;
  localparam logic [PcW-1:0] StepOffCheck = 4'd13;
  localparam logic [PcW-1:0] StepFinish   = 4'd14;

  // Fader state kept between items
  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic [TimeW-1:0]  fade_start;
    logic [TimeW-1:0]  fade_end;
    logic [LevelW-1:0] begin_int;
    logic [CctW-1:0]   begin_cct;
    logic [LevelW-1:0] goal_int;
    logic [CctW-1:0]   goal_cct;
    logic [LevelW-1:0] intensity;
    logic [CctW-1:0]   cct;
    logic [LevelW-1:0] warm;
    logic [LevelW-1:0] cool;
    logic              animating;
  } fade_state_t;

  localparam fade_state_t FadeStateReset = '{
    now_ms:     '0,
    fade_start: '0,
    fade_end:   '0,
    begin_int:  '0,
    begin_cct:  CctMid,
    goal_int:   '0,
    goal_cct:   CctMid,
    intensity:  '0,
    cct:        CctMid,
    warm:       '0,
    cool:       '0,
    animating:  1'b0
  };

  // Scratch registers of the datapath
  typedef struct packed {
    logic [LevelW-1:0] lerp_base;
    logic [LevelW-1:0] lerp_goal;
    logic              lerp_neg;
    logic              lerp_zero;
    logic [LevelW-1:0] map_w;
    logic [LevelW-1:0] map_c;
    logic [ProdW-1:0]  prod;
    logic              strobe;
  } work_t;

  // Result beat
  typedef struct packed {
    logic [LevelW-1:0] warm_level;
    logic [LevelW-1:0] cool_level;
    logic [CctW-1:0]   cct_now;
    logic [LevelW-1:0] intensity_now;
    logic              fading;
    logic              write_strobe;
  } result_t;

  // Microcode program
  function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    w = '{uop: UOP_FINISH, cond: COND_OUT_BLOCKED, target: StepFinish};
    unique case (pc)
      StepDispatch: w = '{uop: UOP_DISPATCH,  cond: COND_NOT_TICK,  target: StepFinish};
      StepTick:     w = '{uop: UOP_TICK,      cond: COND_NOT_ANIM,  target: StepOffCheck};
      StepCheck:    w = '{uop: UOP_CHECK,     cond: COND_TIME_UP,   target: StepOffCheck};
      StepLoadI:    w = '{uop: UOP_LOAD_I,    cond: COND_I_SETTLED, target: StepLoadC};
      StepWaitI:    w = '{uop: UOP_WAIT,      cond: COND_DIV_BUSY,  target: StepWaitI};
      StepWriteI:   w = '{uop: UOP_WRITE_I,   cond: COND_NEXT,      target: StepLoadC};
      StepLoadC:    w = '{uop: UOP_LOAD_C,    cond: COND_C_SETTLED, target: StepMap};
      StepWaitC:    w = '{uop: UOP_WAIT,      cond: COND_DIV_BUSY,  target: StepWaitC};
      StepWriteC:   w = '{uop: UOP_WRITE_C,   cond: COND_NEXT,      target: StepMap};
      StepMap:      w = '{uop: UOP_MAP,       cond: COND_NEXT,      target: StepMulW};
      StepMulW:     w = '{uop: UOP_MUL_W,     cond: COND_NEXT,      target: StepMulC};
      StepMulC:     w = '{uop: UOP_MUL_C,     cond: COND_NEXT,      target: StepScaleC};
      StepScaleC:   w = '{uop: UOP_SCALE_C,   cond: COND_NEXT,      target: StepOffCheck};
      StepOffCheck: w = '{uop: UOP_OFF_CHECK, cond: COND_NEXT,      target: StepFinish};
      default:      w = '{uop: UOP_FINISH,    cond: COND_OUT_BLOCKED, target: StepFinish};
    endcase
    return w;
  endfunction

  // x / 255 for x below 65280, by reciprocal and correction
  function automatic logic [LevelW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] y;
    y = {1'b0, x} + (ProdW+1)'(1) + (ProdW+1)'(x >> LevelW);
    return y[ProdW-1:LevelW];
  endfunction

  // Saturate a level to the colour-temperature range
  function automatic logic [CctW-1:0] cct_clamp(input logic [LevelW-1:0] v);
    logic [CctW-1:0] r;
    r = (v > LevelW'(CctMax)) ? CctMax : v[CctW-1:0];
    return r;
  endfunction

endpackage

FILE: sv/cif_in_if.sv
// Input channel of the fader: one command beat per handshake.
interface cif_in_if import cif_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [LevelW-1:0] target;
  logic [TimeW-1:0]  duration_ms;

  modport source (output valid, op, target, duration_ms, input ready);
  modport sink   (input valid, op, target, duration_ms, output ready);
endinterface

FILE: sv/cif_out_if.sv
// Output channel of the fader: one result beat per handshake.
interface cif_out_if import cif_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] warm_level;
  logic [LevelW-1:0] cool_level;
  logic [CctW-1:0]   cct_now;
  logic [LevelW-1:0] intensity_now;
  logic              fading;
  logic              write_strobe;

  modport source (output valid, warm_level, cool_level, cct_now, intensity_now, fading,
                  write_strobe, input ready);
  modport sink   (input valid, warm_level, cool_level, cct_now, intensity_now, fading,
                  write_strobe, output ready);
endinterface

FILE: sv/cif_div.sv
// Unsigned radix-4 restoring divider, two quotient bits per cycle.
module cif_div import cif_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [TimeW-1:0] divisor_i,
  output logic             busy_o,
  output logic [DivW-1:0]  quot_o
);

  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TimeW:0]   rem_q, rem_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [TimeW-1:0] dsr_q, dsr_d;

  // Two shift-compare-subtract steps per cycle
  always_comb begin
    logic [TimeW:0]  r;
    logic [DivW-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int k = 0; k < 2; k++) begin
      r = {r[TimeW-1:0], q[DivW-1]};
      q = {q[DivW-2:0], 1'b0};
      if (r >= {1'b0, dsr_q}) begin
        r    = r - {1'b0, dsr_q};
        q[0] = 1'b1;
      end
    end
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    if (load_i) begin
      cnt_d = CntW'(DivSteps);
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      rem_d = r;
      quo_d = q;
    end
  end

  // Hold the step count under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

FILE: sv/cct_intensity_fader_unit.sv
// Tunable-white fader top level: microcoded sequencer, datapath and output register.
//
// Takes one command beat at a time and returns one result beat for each. Op 0 ticks the
// millisecond counter, ops 1 and 2 start a linear colour-temperature or intensity fade,
// op 3 sets the colour temperature at once. A tick during a fade uses the shared 40-by-32
// bit divider, which yields two quotient bits per cycle, at most once for intensity and
// once for colour temperature. The output register frees the sequencer as soon as a
// result is latched, so the next beat is taken while that result still waits.
// Configuration is two one-bit registers: lamp on (index 0, reset 1) and automatic
// driver strobe (index 1, reset 0).
module cct_intensity_fader_unit import cif_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  cif_in_if.sink             in_i,
  cif_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // Sequencer and item registers
  logic              busy_q, busy_d;
  logic [PcW-1:0]    pc_q, pc_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [LevelW-1:0] tgt_q, tgt_d;
  logic [TimeW-1:0]  dur_q, dur_d;

  // Fader state, configuration, scratch and result
  fade_state_t st_q, st_d;
  logic        led_on_q, led_on_d;
  logic        auto_wr_q, auto_wr_d;
  work_t       wk_q, wk_d;
  result_t     res_q, res_d;
  logic        out_valid_q, out_valid_d;

  ctrl_word_t  uword;
  logic        in_acc;
  logic        out_blocked;
  logic        time_up;
  logic        cond_hit;
  logic [TimeW-1:0] t_el;
  logic [TimeW-1:0] d_span;

  // Divider interface
  logic              div_load;
  logic [DivW-1:0]   div_dividend;
  logic              div_busy;
  logic [DivW-1:0]   div_quot;

  // Lerp operand and result
  logic [LevelW-1:0] ld_base;
  logic [LevelW-1:0] ld_goal;
  logic              ld_neg;
  logic [LevelW-1:0] ld_mag;
  logic [LevelW-1:0] lerp_hi;
  logic [DivW:0]     lerp_sum;
  logic [LevelW-1:0] lerp_val;

  // Colour map
  logic [5:0]        map_off;
  logic [24:0]       map_prod;
  logic [LevelW-1:0] map_s;

  assign uword       = ucode_rom(pc_q);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_blocked = out_valid_q && !out_o.ready;
  assign time_up     = !(st_q.now_ms < st_q.fade_end);
  assign t_el        = st_q.now_ms - st_q.fade_start;
  assign d_span      = st_q.fade_end - st_q.fade_start;

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uword.cond)
      COND_NOT_TICK:    cond_hit = (op_e'(op_q) != OP_TICK);
      COND_NOT_ANIM:    cond_hit = !st_q.animating;
      COND_TIME_UP:     cond_hit = time_up;
      COND_I_SETTLED:   cond_hit = (st_q.goal_int == st_q.intensity);
      COND_C_SETTLED:   cond_hit = (st_q.goal_cct == st_q.cct);
      COND_DIV_BUSY:    cond_hit = div_busy;
      COND_OUT_BLOCKED: cond_hit = out_blocked;
      default:          cond_hit = 1'b0;
    endcase
  end

  // Select lerp operands for the quantity being loaded
  always_comb begin
    if (uword.uop == UOP_LOAD_C) begin
      ld_base = LevelW'(st_q.begin_cct);
      ld_goal = LevelW'(st_q.goal_cct);
    end else begin
      ld_base = st_q.begin_int;
      ld_goal = st_q.goal_int;
    end
    ld_neg = (ld_goal < ld_base);
    ld_mag = ld_neg ? (ld_base - ld_goal) : (ld_goal - ld_base);
  end

  assign div_dividend = DivW'(ld_mag) * DivW'(t_el);
  assign div_load     = ((uword.uop == UOP_LOAD_I) || (uword.uop == UOP_LOAD_C)) && !cond_hit;

  // Apply the quotient to the start level and saturate; a zero-length fade takes the goal
  assign lerp_hi  = (uword.uop == UOP_WRITE_C) ? LevelW'(CctMax) : LevelMax;
  assign lerp_sum = {1'b0, div_quot} + (DivW+1)'(wk_q.lerp_base);
  always_comb begin
    if (wk_q.lerp_zero) begin
      lerp_val = wk_q.lerp_goal;
    end else if (wk_q.lerp_neg) begin
      lerp_val = (div_quot > DivW'(wk_q.lerp_base)) ? '0
               : (wk_q.lerp_base - div_quot[LevelW-1:0]);
    end else begin
      lerp_val = (lerp_sum > (DivW+1)'(lerp_hi)) ? lerp_hi : lerp_sum[LevelW-1:0];
    end
  end

  // Piecewise colour map: scaled colour temperature up to the midpoint, scaled offset above it
  assign map_off  = (st_q.cct <= CctMid) ? st_q.cct[5:0] : 6'(st_q.cct - CctMid);
  assign map_prod = 25'(map_off) * 25'(MapRecip);
  assign map_s    = map_prod[23:16];

  cif_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i (div_dividend),
    .divisor_i  (d_span),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Execute the current step
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    op_d        = op_q;
    tgt_d       = tgt_q;
    dur_d       = dur_q;
    st_d        = st_q;
    led_on_d    = led_on_q;
    auto_wr_d   = auto_wr_q;
    wk_d        = wk_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    // Drop the result once the beat is taken
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (busy_q) begin
      pc_d = cond_hit ? uword.target : (pc_q + PcW'(1));
      unique case (uword.uop) inside
        UOP_DISPATCH: begin
          wk_d.strobe = 1'b0;
          case (op_e'(op_q)) inside
            OP_FADE_CCT, OP_FADE_INT: begin
              st_d.animating  = 1'b1;
              st_d.fade_start = st_q.now_ms;
              st_d.fade_end   = st_q.now_ms + dur_q;
              st_d.begin_cct  = st_q.cct;
              st_d.begin_int  = st_q.intensity;
              if (op_e'(op_q) == OP_FADE_CCT) begin
                st_d.goal_cct = cct_clamp(tgt_q);
              end else begin
                st_d.goal_int = tgt_q;
              end
            end
            OP_SET_CCT: st_d.cct = cct_clamp(tgt_q);
            default: ;
          endcase
        end
        UOP_TICK: begin
          st_d.now_ms = st_q.now_ms + TimeW'(1);
          wk_d.strobe = st_q.animating && auto_wr_q;
        end
        UOP_CHECK: begin
          if (time_up) begin
            st_d.intensity = st_q.goal_int;
            st_d.cct       = st_q.goal_cct;
            st_d.animating = 1'b0;
          end
        end
        UOP_LOAD_I, UOP_LOAD_C: begin
          wk_d.lerp_base = ld_base;
          wk_d.lerp_goal = ld_goal;
          wk_d.lerp_neg  = ld_neg;
          wk_d.lerp_zero = (d_span == '0);
        end
        UOP_WAIT: ;
        UOP_WRITE_I: st_d.intensity = lerp_val;
        UOP_WRITE_C: st_d.cct       = lerp_val[CctW-1:0];
        UOP_MAP: begin
          if (st_q.cct <= CctMid) begin
            wk_d.map_w = LevelMax;
            wk_d.map_c = map_s;
          end else begin
            wk_d.map_w = LevelMax - map_s;
            wk_d.map_c = LevelMax;
          end
        end
        UOP_MUL_W: wk_d.prod = ProdW'(wk_q.map_w) * ProdW'(st_q.intensity);
        UOP_MUL_C: begin
          st_d.warm = div255(wk_q.prod);
          wk_d.prod = ProdW'(wk_q.map_c) * ProdW'(st_q.intensity);
        end
        UOP_SCALE_C: st_d.cool = div255(wk_q.prod);
        UOP_OFF_CHECK: begin
          if (!st_q.animating && !led_on_q) begin
            st_d.intensity = '0;
          end
        end
        UOP_FINISH: begin
          if (!out_blocked) begin
            res_d.warm_level    = st_q.warm;
            res_d.cool_level    = st_q.cool;
            res_d.cct_now       = st_q.cct;
            res_d.intensity_now = st_q.intensity;
            res_d.fading        = st_q.animating;
            res_d.write_strobe  = wk_q.strobe;
            out_valid_d         = 1'b1;
            busy_d              = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Accept a new command beat
    if (in_acc) begin
      busy_d = 1'b1;
      pc_d   = StepDispatch;
      op_d   = in_i.op;
      tgt_d  = in_i.target;
      dur_d  = in_i.duration_ms;
    end

    // Take configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LED_ON:     led_on_d  = cfg_data_i[0];
        CFG_AUTO_WRITE: auto_wr_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control and fader state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= StepDispatch;
      st_q        <= FadeStateReset;
      led_on_q    <= 1'b1;
      auto_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      st_q        <= st_d;
      led_on_q    <= led_on_d;
      auto_wr_q   <= auto_wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    tgt_q <= tgt_d;
    dur_q <= dur_d;
    wk_q  <= wk_d;
    res_q <= res_d;
  end

  assign in_i.ready          = !busy_q;
  assign out_o.valid         = out_valid_q;
  assign out_o.warm_level    = res_q.warm_level;
  assign out_o.cool_level    = res_q.cool_level;
  assign out_o.cct_now       = res_q.cct_now;
  assign out_o.intensity_now = res_q.intensity_now;
  assign out_o.fading        = res_q.fading;
  assign out_o.write_strobe  = res_q.write_strobe;

  // A fade ends only on the end-time check
  a_fade_ends_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(st_q.animating) |-> $past(uword.uop == UOP_CHECK))
    else $error("fade ended outside the end-time check");

  // Colour temperature stays in range
  a_cct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cct <= CctMax)
    else $error("colour temperature out of range");

  // The divider is never left running once the item is done
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !div_busy)
    else $error("divider busy while sequencer idle");

  // A result appears only from the finishing step
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && pc_q == StepFinish))
    else $error("result raised outside the finishing step");

endmodule
